[design/assert_macros.svh]
// Assertion macros shared by the free-list pool RTL.
// Depends on a clk and a rst signal in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FLP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flp assertion failed");

`endif

[design/flp_pkg.sv]
// Shared types and constants for the free-list pool with linked queue.
// No dependencies; imported by every module of the block.
package flp_pkg;

  localparam int ENTRIES = 16;
  localparam int ENT_W   = 4;   // bits of an entry index
  localparam int CNT_W   = 5;   // bits of a count, holds ENTRIES itself

  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_ENQUEUE = 2'd2;
  localparam logic [1:0] OP_DEQUEUE = 2'd3;

  // Control from the sequencer to both link units.
  typedef struct packed {
    logic             issue;   // start link memory read at the current head
    logic             exec;    // commit the operation
    logic [1:0]       opcode;
    logic [ENT_W-1:0] entry;
  } flp_ctl_t;

  // Outcome of the free stack for the current word.
  typedef struct packed {
    logic             ok;
    logic [ENT_W-1:0] got;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] peak;
  } flp_pool_t;

  // Outcome of the queue for the current word.
  typedef struct packed {
    logic             ok;
    logic [ENT_W-1:0] got;
    logic [CNT_W-1:0] count;
  } flp_que_t;

endpackage

[design/flp_free_list.sv]
// Free entry stack: link memory, valid bits, head, free count and peak.
// Depends on flp_pkg.
module flp_free_list import flp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  flp_ctl_t  ctl,
  output flp_pool_t res
);

  logic [ENT_W-1:0] link_mem [ENTRIES];
  logic [ENTRIES-1:0] link_vld;
  logic [ENT_W-1:0] rd_data;
  logic             rd_vld;

  logic [ENT_W-1:0] head;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] peak;

  logic [ENT_W-1:0] link_val;
  logic [ENT_W-1:0] head_next;
  logic [CNT_W-1:0] total_next;
  logic [CNT_W-1:0] peak_next;
  logic [CNT_W-1:0] used_next;
  logic             entry_ok;
  logic             do_wr;

  always_comb begin
    // An unwritten link holds its reset value: the entry below it.
    link_val   = rd_vld ? rd_data : ((head == '0) ? '0 : head - 1'b1);
    entry_ok   = (CNT_W'(ctl.entry) < ENTRIES_C);
    head_next  = head;
    total_next = total;
    peak_next  = peak;
    used_next  = '0;
    do_wr      = 1'b0;
    res.ok     = 1'b0;
    res.got    = '0;
    case (ctl.opcode)
      OP_ACQUIRE: begin
        if (total != '0) begin
          head_next  = link_val;
          total_next = total - 1'b1;
          used_next  = ENTRIES_C - total_next;
          if (used_next > peak) begin
            peak_next = used_next;
          end
          res.ok  = 1'b1;
          res.got = head;
        end
      end
      OP_RELEASE: begin
        if (entry_ok && (total < ENTRIES_C)) begin
          do_wr      = 1'b1;
          head_next  = ctl.entry;
          total_next = total + 1'b1;
          res.ok     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count = total_next;
    res.peak  = peak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= ENT_W'(ENTRIES - 1);
      total <= ENTRIES_C;
      peak  <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      total <= total_next;
      peak  <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (ctl.exec && do_wr) begin
        link_vld[ctl.entry] <= 1'b1;
      end
      if (ctl.issue) begin
        rd_vld <= link_vld[head];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_wr) begin
      link_mem[ctl.entry] <= head;
    end
    if (ctl.issue) begin
      rd_data <= link_mem[head];
    end
  end

endmodule

[design/flp_queue.sv]
// Linked FIFO queue of entries: link memory, head, tail and count.
// Depends on flp_pkg.
module flp_queue import flp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  flp_ctl_t ctl,
  output flp_que_t res
);

  logic [ENT_W-1:0] link_mem [ENTRIES];
  logic [ENT_W-1:0] rd_data;

  logic [ENT_W-1:0] head;
  logic [ENT_W-1:0] tail;
  logic [CNT_W-1:0] total;

  logic [ENT_W-1:0] head_next;
  logic [ENT_W-1:0] tail_next;
  logic [CNT_W-1:0] total_next;
  logic             entry_ok;
  logic             do_wr;

  always_comb begin
    entry_ok   = (CNT_W'(ctl.entry) < ENTRIES_C);
    head_next  = head;
    tail_next  = tail;
    total_next = total;
    do_wr      = 1'b0;
    res.ok     = 1'b0;
    res.got    = '0;
    case (ctl.opcode)
      OP_ENQUEUE: begin
        if (entry_ok && (total < ENTRIES_C)) begin
          if (total == '0) begin
            head_next = ctl.entry;
          end else begin
            do_wr = 1'b1;
          end
          tail_next  = ctl.entry;
          total_next = total + 1'b1;
          res.ok     = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (total != '0) begin
          total_next = total - 1'b1;
          if (total_next == '0) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = rd_data;
          end
          res.ok  = 1'b1;
          res.got = head;
        end
      end
      default: begin
      end
    endcase
    res.count = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      total <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_wr) begin
      link_mem[tail] <= ctl.entry;
    end
    if (ctl.issue) begin
      rd_data <= link_mem[head];
    end
  end

endmodule

[design/free_list_pool_with_fifo_queue_core.sv]
// Top level of the free-list buffer pool with one linked FIFO queue.
// Depends on flp_pkg, flp_free_list, flp_queue and assert_macros.svh.
//
// Each input word carries an opcode (acquire, release, enqueue, dequeue) and
// an entry index; each one yields exactly one result word with a success flag,
// the entry handed out (zero unless an acquire or dequeue succeeds), and the
// free, peak-in-use and queued counts after the operation. Free entries form a
// LIFO stack and queued entries a FIFO, both threaded through synchronous link
// memories. For each word, the accept edge starts the link memory read at the
// current head, and the commit edge updates the heads and counts, writes the
// link memory and loads the output register. The block takes no new word until
// the current one commits, since that memory read must come before each update.
// The output register lets the next word be accepted while a result still
// waits; if the result is still not taken when the next word is ready to
// commit, that word holds in its update cycle. The free link memory has a
// valid bit per entry, so reset takes effect at once with no clearing pass;
// queue links are only read after they are written.
`include "assert_macros.svh"

module free_list_pool_with_fifo_queue_core import flp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] opcode, [5:2] entry, [7:6] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] ok, [4:1] entry_out, [9:5] free_count,
                                 // [14:10] peak_used, [19:15] queued_count,
                                 // [23:20] zero
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  logic [1:0]       opcode;
  logic [ENT_W-1:0] entry;

  logic      accept;
  logic      exec;
  flp_ctl_t  ctl;
  flp_pool_t pool_res;
  flp_que_t  que_res;

  logic             res_ok;
  logic [ENT_W-1:0] res_got;

  logic [CNT_W-1:0] out_free;
  logic [CNT_W-1:0] out_peak;
  logic [ENT_W-1:0] out_entry;
  logic             out_ok;

  // Take a word only between operations; commit once the output slot frees.
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign exec     = (state == ST_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    ctl.issue  = accept;
    ctl.exec   = exec;
    ctl.opcode = opcode;
    ctl.entry  = entry;
  end

  flp_free_list u_free (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .res (pool_res)
  );

  flp_queue u_queue (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .res (que_res)
  );

  // Pool operations have opcode bit 1 clear; queue operations have it set.
  always_comb begin
    if (opcode[1]) begin
      res_ok  = que_res.ok;
      res_got = que_res.got;
    end else begin
      res_ok  = pool_res.ok;
      res_got = pool_res.got;
    end
  end

  // Sequencer: latch the word on accept, commit on the following edge or later.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode <= s_tdata[1:0];
      entry  <= s_tdata[5:2];
    end
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      m_tdata <= {4'b0000, que_res.count, pool_res.peak, pool_res.count,
                  res_got, res_ok};
    end
  end

  assign out_ok    = m_tdata[0];
  assign out_entry = m_tdata[4:1];
  assign out_free  = m_tdata[9:5];
  assign out_peak  = m_tdata[14:10];

  `FLP_ASSERT_NEXT(a_accept_to_exec, accept, (state == ST_EXEC) && !s_tready)
  `FLP_ASSERT_NOW(a_fail_entry_zero, m_tvalid && !out_ok, out_entry == '0)
  `FLP_ASSERT_NOW(a_free_bounded, m_tvalid, out_free <= ENTRIES_C)
  `FLP_ASSERT_NOW(a_peak_covers_use, m_tvalid,
                  ({1'b0, out_peak} + {1'b0, out_free}) >= {1'b0, ENTRIES_C})

endmodule
